/* rtl/core/stack_expression_evaluator_assert.svh */
// ----------------------------------------------------------------------------
// Stack expression evaluator - assertion macros
// Shared concurrent checks, clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef STACK_EXPRESSION_EVALUATOR_ASSERT_SVH
`define STACK_EXPRESSION_EVALUATOR_ASSERT_SVH

// same-cycle implication
`define SEE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SEE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/see_pkg.sv */
// ----------------------------------------------------------------------------
// see_pkg
// Shared types and constants of the stack expression evaluator.
// ----------------------------------------------------------------------------
package see_pkg;

  localparam int STACK_DEPTH_DEF = 128;
  localparam int DATA_W          = 32;

  // expression characters
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PCT   = 8'h25;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_UNDERFLOW = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_DIVZERO   = 3'd3,
    ST_BADSYM    = 3'd4,
    ST_LEFTOVER  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_MOD
  } op_t;

  typedef struct packed {
    logic              start;
    op_t               op;
    logic [DATA_W-1:0] lhs;
    logic [DATA_W-1:0] rhs;
  } alu_req_t;

  typedef struct packed {
    logic              done;
    logic              div_zero;
    logic [DATA_W-1:0] result;
  } alu_rsp_t;

endpackage

/* rtl/core/see_stack.sv */
// ----------------------------------------------------------------------------
// see_stack
// Operand stack storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module see_stack #(
  parameter  int DEPTH = see_pkg::STACK_DEPTH_DEF,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [see_pkg::DATA_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [see_pkg::DATA_W-1:0] rdata
);

  logic [see_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/see_alu.sv */
// ----------------------------------------------------------------------------
// see_alu
// Shared arithmetic unit: add, sub, mul with a registered result; signed div and mod
// through a radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module see_alu (
  input  logic              clk,
  input  logic              rst,
  input  see_pkg::alu_req_t req,
  output see_pkg::alu_rsp_t rsp
);

  localparam int W  = see_pkg::DATA_W;
  localparam int CW = $clog2(W);

  typedef enum logic [1:0] {
    A_IDLE,
    A_DIV,
    A_FIX
  } alu_state_t;

  alu_state_t     state;
  see_pkg::op_t   op_q;
  logic [W-1:0]   rem;
  logic [W-1:0]   quo;
  logic [W-1:0]   dvs;
  logic [CW-1:0]  cnt;
  logic           q_neg;
  logic           r_neg;

  logic [W:0]     rem_sh;
  logic [W:0]     diff;
  logic [W-1:0]   lhs_mag;
  logic [W-1:0]   rhs_mag;

  always_comb begin
    rem_sh  = {rem, quo[W-1]};
    diff    = rem_sh - {1'b0, dvs};
    lhs_mag = req.lhs[W-1] ? (~req.lhs + W'(1)) : req.lhs;
    rhs_mag = req.rhs[W-1] ? (~req.rhs + W'(1)) : req.rhs;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= A_IDLE;
      rsp.done     <= 1'b0;
      rsp.div_zero <= 1'b0;
    end else begin
      rsp.done     <= 1'b0;
      rsp.div_zero <= 1'b0;
      case (state)
        A_IDLE: begin
          if (req.start) begin
            op_q <= req.op;
            case (req.op)
              see_pkg::OP_ADD: begin
                rsp.result <= req.lhs + req.rhs;
                rsp.done   <= 1'b1;
              end
              see_pkg::OP_SUB: begin
                rsp.result <= req.lhs - req.rhs;
                rsp.done   <= 1'b1;
              end
              see_pkg::OP_MUL: begin
                rsp.result <= W'(req.lhs * req.rhs);
                rsp.done   <= 1'b1;
              end
              default: begin
                if (req.rhs == '0) begin
                  rsp.div_zero <= 1'b1;
                  rsp.done     <= 1'b1;
                end else begin
                  rem   <= '0;
                  quo   <= lhs_mag;
                  dvs   <= rhs_mag;
                  cnt   <= '0;
                  q_neg <= req.lhs[W-1] ^ req.rhs[W-1];
                  r_neg <= req.lhs[W-1];
                  state <= A_DIV;
                end
              end
            endcase
          end
        end
        A_DIV: begin
          if (!diff[W]) begin
            rem <= diff[W-1:0];
            quo <= {quo[W-2:0], 1'b1};
          end else begin
            rem <= rem_sh[W-1:0];
            quo <= {quo[W-2:0], 1'b0};
          end
          cnt <= cnt + CW'(1);
          if (cnt == CW'(W - 1)) begin
            state <= A_FIX;
          end
        end
        A_FIX: begin
          // quotient sign from both operands, remainder follows the dividend
          if (op_q == see_pkg::OP_DIV) begin
            rsp.result <= q_neg ? (~quo + W'(1)) : quo;
          end else begin
            rsp.result <= r_neg ? (~rem + W'(1)) : rem;
          end
          rsp.done <= 1'b1;
          state    <= A_IDLE;
        end
        default: state <= A_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/stack_expression_evaluator.sv */
// ----------------------------------------------------------------------------
// stack_expression_evaluator
// Postfix / prefix expression evaluator with an operand stack in memory.
// ----------------------------------------------------------------------------
// One expression character arrives per input transfer (s_tdata[7:0], with
// s_tlast on the final one). Digits push 0..9; + - * / % pop two operands
// and push the signed 32-bit wrapped result, with C truncating division.
// prefix_mode (cfg_wen/cfg_wdata) set to 1 takes a prefix expression fed
// right to left: top of stack becomes the left operand. After the last
// character one result transfer carries value and status (0 ok, 1 underflow,
// 2 overflow, 3 divide by zero, 4 bad symbol, 5 leftover operands); value is
// zero on any error, the first error of an expression wins, and the stack is
// emptied. The block handles one character at a time and s_tready is low
// while it works: a digit is decoded and pushed; + - * / % also read two
// operands and wait on the shared unit, whose radix-2 divider makes 32
// passes for / and %; the last character adds a memory read of the bottom
// entry plus the output load, or only the load when the status needs no
// read. The stack memory has one write and one registered read port, so
// each operator fetches its operands one after the other. A finished result
// sits in the output register while the next expression already streams in.
// ----------------------------------------------------------------------------
module stack_expression_evaluator #(
  parameter int STACK_DEPTH = see_pkg::STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input characters
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] symbol
  input  logic        s_tlast,   // last character of the expression
  // results
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] value, [34:32] status, [39:35] zero
  // prefix_mode register
  input  logic        cfg_wen,
  input  logic        cfg_wdata
);

  `include "stack_expression_evaluator_assert.svh"

  localparam int W  = see_pkg::DATA_W;
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_RD1,
    S_RD2,
    S_EXEC,
    S_END,
    S_RD0,
    S_OUT
  } state_t;

  state_t            state;
  logic [7:0]        sym_q;
  logic              last_q;
  logic [CW-1:0]     sp;          // entries in use
  see_pkg::status_t  err;         // sticky, first error wins
  logic [W-1:0]      top_q;       // top operand, fetched first
  logic              prefix_mode;
  logic [W-1:0]      res_value;
  see_pkg::status_t  res_status;
  logic [W-1:0]      out_value;
  see_pkg::status_t  out_status;

  // stack port
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [W-1:0]      mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [W-1:0]      mem_rdata;

  see_pkg::alu_req_t alu_req;
  see_pkg::alu_rsp_t alu_rsp;

  logic              is_digit;
  logic              is_op;
  see_pkg::op_t      op_dec;
  see_pkg::op_t      op_q;
  logic [CW-1:0]     sp_m1;
  logic [CW-1:0]     sp_m2;

  logic              alu_ok;      // unit result that gets pushed
  logic              out_err;     // output register holds an error status
  logic              expr_clr;    // stack empty, no error latched

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = {5'b0, out_status, out_value};
  assign sp_m1    = sp - CW'(1);
  assign sp_m2    = sp - CW'(2);
  assign alu_ok   = alu_rsp.done && !alu_rsp.div_zero;
  assign out_err  = (out_status != see_pkg::ST_OK);
  assign expr_clr = (sp == '0) && (err == see_pkg::ST_OK);

  // symbol decode
  always_comb begin
    is_digit = (sym_q inside {[see_pkg::CH_0:see_pkg::CH_9]});
    is_op    = 1'b1;
    op_dec   = see_pkg::OP_ADD;
    case (sym_q)
      see_pkg::CH_PLUS:  op_dec = see_pkg::OP_ADD;
      see_pkg::CH_MINUS: op_dec = see_pkg::OP_SUB;
      see_pkg::CH_STAR:  op_dec = see_pkg::OP_MUL;
      see_pkg::CH_SLASH: op_dec = see_pkg::OP_DIV;
      see_pkg::CH_PCT:   op_dec = see_pkg::OP_MOD;
      default:           is_op  = 1'b0;
    endcase
  end

  // memory and unit control
  always_comb begin
    mem_we        = 1'b0;
    mem_waddr     = sp[AW-1:0];
    mem_wdata     = {{(W-4){1'b0}}, sym_q[3:0]};
    mem_re        = 1'b0;
    mem_raddr     = sp_m1[AW-1:0];
    alu_req.start = 1'b0;
    alu_req.op    = op_q;
    alu_req.lhs   = prefix_mode ? top_q : mem_rdata;
    alu_req.rhs   = prefix_mode ? mem_rdata : top_q;
    case (state)
      S_DECODE: begin
        if (err == see_pkg::ST_OK) begin
          if (is_digit && sp < CW'(STACK_DEPTH)) begin
            mem_we = 1'b1;
          end else if (is_op && sp >= CW'(2)) begin
            mem_re = 1'b1;
          end
        end
      end
      S_RD1: begin
        mem_re    = 1'b1;
        mem_raddr = sp_m2[AW-1:0];
      end
      S_RD2: begin
        alu_req.start = 1'b1;
      end
      S_EXEC: begin
        if (alu_ok) begin
          mem_we    = 1'b1;
          mem_waddr = sp_m2[AW-1:0];
          mem_wdata = alu_rsp.result;
        end
      end
      S_END: begin
        if (last_q && err == see_pkg::ST_OK && sp == CW'(1)) begin
          mem_re    = 1'b1;
          mem_raddr = '0;
        end
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      sp          <= '0;
      err         <= see_pkg::ST_OK;
      prefix_mode <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_wen) begin
        prefix_mode <= cfg_wdata;
      end
      // in S_OUT a taken result is replaced by the next one below
      if (m_tvalid && m_tready && state != S_OUT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            sym_q  <= s_tdata;
            last_q <= s_tlast;
            state  <= S_DECODE;
          end
        end
        S_DECODE: begin
          state <= S_END;
          op_q  <= op_dec;
          if (err == see_pkg::ST_OK) begin
            if (is_digit) begin
              if (sp >= CW'(STACK_DEPTH)) begin
                err <= see_pkg::ST_OVERFLOW;
              end else begin
                sp <= sp + CW'(1);
              end
            end else if (is_op) begin
              if (sp < CW'(2)) begin
                err <= see_pkg::ST_UNDERFLOW;
              end else begin
                state <= S_RD1;
              end
            end else begin
              err <= see_pkg::ST_BADSYM;
            end
          end
        end
        S_RD1: begin
          top_q <= mem_rdata;
          state <= S_RD2;
        end
        S_RD2: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          if (alu_rsp.done) begin
            if (alu_rsp.div_zero) begin
              err <= see_pkg::ST_DIVZERO;
            end else begin
              sp <= sp_m1;
            end
            state <= S_END;
          end
        end
        S_END: begin
          res_value <= '0;
          if (!last_q) begin
            state <= S_IDLE;
          end else if (err != see_pkg::ST_OK) begin
            res_status <= err;
            state      <= S_OUT;
          end else if (sp == '0) begin
            res_status <= see_pkg::ST_UNDERFLOW;
            state      <= S_OUT;
          end else if (sp > CW'(1)) begin
            res_status <= see_pkg::ST_LEFTOVER;
            state      <= S_OUT;
          end else begin
            state <= S_RD0;
          end
        end
        S_RD0: begin
          res_value  <= mem_rdata;
          res_status <= see_pkg::ST_OK;
          state      <= S_OUT;
        end
        S_OUT: begin
          // wait for the output register to free up
          if (!m_tvalid || m_tready) begin
            out_value  <= res_value;
            out_status <= res_status;
            m_tvalid   <= 1'b1;
            sp         <= '0;
            err        <= see_pkg::ST_OK;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  see_stack #(
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  see_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .rsp (alu_rsp)
  );

  `SEE_ASSERT_NOW(a_sp_bound, 1'b1, sp <= CW'(STACK_DEPTH), "stack pointer past depth")
  `SEE_ASSERT_NOW(a_done_in_exec, alu_rsp.done, state == S_EXEC, "unit result outside exec")
  `SEE_ASSERT_NOW(a_clear_on_result, $rose(m_tvalid), expr_clr, "stack not cleared")
  `SEE_ASSERT_NOW(a_err_value_zero, m_tvalid && out_err, out_value == '0, "value on error")
  `SEE_ASSERT_NEXT(a_pop_one, alu_ok, sp == $past(sp) - CW'(1), "operator did not net one pop")

endmodule
